// ----- rtl/mzp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mzp_pkg;

	localparam int MAX_CELLS      = 64;
	localparam int LINKS_PER_CELL = 4;
	localparam int INPUT_LINKS    = 4;

	localparam int CELL_W  = $clog2(MAX_CELLS);
	localparam int CNT_W   = $clog2(MAX_CELLS + 1);
	localparam int LINK_W  = 7;
	localparam int CFG_W   = 7;
	localparam int LIDX_W  = (LINKS_PER_CELL > 1) ? $clog2(LINKS_PER_CELL) : 1;
	localparam int ENTRY_W = LINKS_PER_CELL * LINK_W;

	localparam logic [LINK_W-1:0] LINK_NONE = '1;
	localparam logic [CFG_W-1:0]  NUM_CELLS_RESET = CFG_W'(MAX_CELLS);

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_SOLVE = 1'b1;

	localparam logic STATUS_PATH  = 1'b0;
	localparam logic STATUS_NONE  = 1'b1;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_LOOK    = 7'b0000010,
		S_SCAN    = 7'b0000100,
		S_POP     = 7'b0001000,
		S_EMIT_RD = 7'b0010000,
		S_EMIT_WR = 7'b0100000,
		S_FAIL    = 7'b1000000
	} state_t;

	typedef struct packed {
		logic              ok;
		logic [CELL_W-1:0] dest;
	} link_chk_t;

endpackage

`default_nettype wire

// ----- rtl/mzp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mzp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mzp_link_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mzp_link_chk
	import mzp_pkg::*;
(
	input  wire logic [LINK_W-1:0]    link,
	input  wire logic [CNT_W-1:0]     n_eff,
	input  wire logic [MAX_CELLS-1:0] visited,
	output link_chk_t                 res
);

	logic [CELL_W-1:0] nb_cell;
	logic              in_range;

	always_comb begin
		nb_cell  = CELL_W'(link[LINK_W-2:0]);
		// range check on the full field, before any narrowing
		in_range = !link[LINK_W-1] && (CNT_W'(link[LINK_W-2:0]) < n_eff);
		res.dest = nb_cell;
		res.ok   = in_range && !visited[nb_cell];
	end

endmodule

`default_nettype wire

// ----- rtl/maze_path_dfs_solver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Load transfer: accepted while idle, no result.
// Solve transfer: input stalls while the search runs; each forward step tries links one at a
// time through the one link checker, each backtrack adds a stack read, then each path cell is
// read back from the stack for output, all limited by the one read port of each memory.
// Reset (arst_n low): sequencer idle, output empty, num_cells 64, visited map clear;
// link table and stack contents stay undefined until written.

module maze_path_dfs_solver
	import mzp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,    // num_cells
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [39:0]      s_axis_tdata,   // cell_index, link_zero .. link_three, pad
	input  wire logic             s_axis_tuser,   // func
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic      [7:0]       m_axis_tdata,   // path_cell, pad
	output logic                  m_axis_tuser,   // status
	output logic                  m_axis_tlast    // last
);

	state_t               state_q;
	logic [CFG_W-1:0]     num_cells_q;
	logic [MAX_CELLS-1:0] visited_q;
	logic [CNT_W-1:0]     depth_q;
	logic [CELL_W-1:0]    top_q;
	logic [LIDX_W-1:0]    lidx_q;
	logic [CELL_W-1:0]    emit_idx_q;
	logic                 out_valid_q;
	logic [5:0]           out_cell_q;
	logic                 out_status_q;
	logic                 out_last_q;

	logic [CNT_W-1:0]     n_eff;
	logic [CELL_W-1:0]    goal;
	logic                 in_xfer;
	logic                 out_free;
	logic                 out_load;
	logic [5:0]           in_cell;
	logic [LINK_W-1:0]    in_links [INPUT_LINKS];
	logic [ENTRY_W-1:0]   entry_wdata;
	logic                 link_we;
	logic                 link_re;
	logic [ENTRY_W-1:0]   link_rdata;
	logic [LINK_W-1:0]    cur_link;
	link_chk_t            chk;
	logic                 scan_end;
	logic                 push;
	logic                 stk_we;
	logic [CELL_W-1:0]    stk_waddr;
	logic [CELL_W-1:0]    stk_wdata;
	logic                 stk_re;
	logic [CELL_W-1:0]    stk_raddr;
	logic [CELL_W-1:0]    stk_rdata;
	logic [CNT_W-1:0]     depth_m2;

	always_comb begin
		if (num_cells_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (CNT_W'(num_cells_q) > CNT_W'(MAX_CELLS)) begin
			n_eff = CNT_W'(MAX_CELLS);
		end else begin
			n_eff = CNT_W'(num_cells_q);
		end
		goal = CELL_W'(n_eff - CNT_W'(1));
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = ((state_q == S_EMIT_WR) || (state_q == S_FAIL)) && out_free;

	assign in_cell     = s_axis_tdata[5:0];
	assign in_links[0] = s_axis_tdata[12:6];
	assign in_links[1] = s_axis_tdata[19:13];
	assign in_links[2] = s_axis_tdata[26:20];
	assign in_links[3] = s_axis_tdata[33:27];

	always_comb begin
		for (int i = 0; i < LINKS_PER_CELL; i++) begin
			if (i < INPUT_LINKS) begin
				entry_wdata[i*LINK_W +: LINK_W] = in_links[i];
			end else begin
				entry_wdata[i*LINK_W +: LINK_W] = LINK_NONE;
			end
		end
	end

	// drop loads beyond the cells in use
	assign link_we = in_xfer && (s_axis_tuser == FUNC_LOAD) && (CNT_W'(in_cell) < n_eff);
	assign link_re = (state_q == S_LOOK) && (top_q != goal);

	mzp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_CELLS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(CELL_W'(in_cell)),
		.wdata(entry_wdata),
		.re   (link_re),
		.raddr(top_q),
		.rdata(link_rdata)
	);

	assign cur_link = link_rdata[lidx_q*LINK_W +: LINK_W];

	mzp_link_chk u_chk (
		.link   (cur_link),
		.n_eff  (n_eff),
		.visited(visited_q),
		.res    (chk)
	);

	assign scan_end = (lidx_q == LIDX_W'(LINKS_PER_CELL - 1));
	assign push     = (state_q == S_SCAN) && chk.ok;
	assign depth_m2 = depth_q - CNT_W'(2);

	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		if (in_xfer && (s_axis_tuser == FUNC_SOLVE)) begin
			stk_we = 1'b1;
		end else if (push && (depth_q < CNT_W'(MAX_CELLS))) begin
			stk_we    = 1'b1;
			stk_waddr = depth_q[CELL_W-1:0];
			stk_wdata = chk.dest;
		end
	end

	always_comb begin
		stk_re    = 1'b0;
		stk_raddr = emit_idx_q;
		if (state_q == S_EMIT_RD) begin
			stk_re = 1'b1;
		end else if ((state_q == S_SCAN) && !chk.ok && scan_end) begin
			// fetch the cell under the top ahead of the pop
			stk_re    = 1'b1;
			stk_raddr = depth_m2[CELL_W-1:0];
		end
	end

	mzp_ram #(
		.WIDTH(CELL_W),
		.DEPTH(MAX_CELLS)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (stk_re),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cells_q <= NUM_CELLS_RESET;
		end else if (cfg_wr_en) begin
			num_cells_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			visited_q    <= '0;
			depth_q      <= '0;
			top_q        <= '0;
			lidx_q       <= '0;
			emit_idx_q   <= '0;
			out_valid_q  <= 1'b0;
			out_cell_q   <= '0;
			out_status_q <= STATUS_PATH;
			out_last_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && (s_axis_tuser == FUNC_SOLVE)) begin
						visited_q <= MAX_CELLS'(1);
						depth_q   <= CNT_W'(1);
						top_q     <= '0;
						state_q   <= S_LOOK;
					end
				end
				S_LOOK: begin
					lidx_q <= '0;
					if (top_q == goal) begin
						emit_idx_q <= '0;
						state_q    <= S_EMIT_RD;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (chk.ok) begin
						visited_q[chk.dest] <= 1'b1;
						if (depth_q < CNT_W'(MAX_CELLS)) begin
							depth_q <= depth_q + CNT_W'(1);
						end
						top_q   <= chk.dest;
						state_q <= S_LOOK;
					end else if (scan_end) begin
						depth_q <= depth_q - CNT_W'(1);
						if (depth_q == CNT_W'(1)) begin
							state_q <= S_FAIL;
						end else begin
							state_q <= S_POP;
						end
					end else begin
						lidx_q <= lidx_q + LIDX_W'(1);
					end
				end
				S_POP: begin
					top_q   <= stk_rdata;
					state_q <= S_LOOK;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (out_free) begin
						out_status_q <= STATUS_PATH;
						out_cell_q   <= 6'(stk_rdata);
						out_last_q   <= (CNT_W'(emit_idx_q) + CNT_W'(1) == depth_q);
						if (CNT_W'(emit_idx_q) + CNT_W'(1) == depth_q) begin
							state_q <= S_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + CELL_W'(1);
							state_q    <= S_EMIT_RD;
						end
					end
				end
				S_FAIL: begin
					if (out_free) begin
						out_status_q <= STATUS_NONE;
						out_cell_q   <= '0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_cell_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/mzp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mzp_checker
	import mzp_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             cfg_wr_en,
	input wire logic [CFG_W-1:0] cfg_wr_data,
	input wire logic             s_axis_tvalid,
	input wire logic             s_axis_tready,
	input wire logic [39:0]      s_axis_tdata,
	input wire logic             s_axis_tuser,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [7:0]       m_axis_tdata,
	input wire logic             m_axis_tuser,
	input wire logic             m_axis_tlast
);

	// a solve transfer stalls the input side
	a_solve_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_SOLVE) |=> !s_axis_tready)
		else $error("input ready right after a solve transfer");

	// mid-path results only appear while the search holds the input
	a_path_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready during path output");

	// the no-path result is a single cell-zero last transfer
	a_no_path: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == STATUS_NONE) |-> m_axis_tlast && (m_axis_tdata == 8'd0))
		else $error("malformed no-path result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output changed while stalled");

endmodule

bind maze_path_dfs_solver mzp_checker u_mzp_checker (.*);

`default_nettype wire
